// ===== hdl/rstc_pkg.sv =====
// Package: sizes, item kind codes and index helpers for the region sum block.
`default_nettype none
package rstc_pkg;

  localparam int BINS      = 1024;
  localparam int SUM_WIDTH = 48;
  localparam int IDX_W     = (BINS > 1) ? $clog2(BINS) : 1;

  localparam int SAMPLE_W  = 32;
  localparam int REGION_W  = 16;
  localparam int RSUM_W    = 48;
  localparam int COUNT_W   = 32;
  localparam int RCOUNT_W  = 11;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] KIND_ACC  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_CLR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 8'd1;

  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic [IDX_W-1:0]            idx_t;

endpackage
`default_nettype wire

// ===== hdl/rstc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module rstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/region_sum_and_threshold_count_top.sv =====
// Top level: weighted histogram with per-region saturating sums and active count.
//
// Usage:
//   Items enter on the item channel (kind, sample, region) with item_valid and
//   item_ready; each item yields exactly one result (region_sum, active_count)
//   on the result channel with result_valid and result_ready.
//   Configuration (threshold, bin limit) is written on the cfg channel,
//   which is always ready; index 0 is threshold, 1 is the bin limit.
//   Accumulate and read items first do the bin RAM read, then the saturating
//   add, write-back and result register load. The next item is accepted in
//   the cycle after the write-back, so a new item is not taken before the
//   last one has been written back.
//   A clear item runs a sweep over all BINS (1024) bin RAM entries that zeroes
//   them, then returns its result.
//   After reset the same sweep runs before item_ready goes high.
//   If the receiver stalls, the finished result stays in the output register;
//   a new item is still taken, but its result waits until the register frees.
`default_nettype none
module region_sum_and_threshold_count_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic signed [rstc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [rstc_pkg::REGION_W-1:0] region,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic signed [rstc_pkg::RSUM_W-1:0] region_sum,
  output logic [rstc_pkg::COUNT_W-1:0]       active_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rstc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import rstc_pkg::*;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic signed [SAMPLE_W-1:0] threshold;
  logic [RCOUNT_W-1:0]        bin_limit;

  // latched item
  logic [1:0]                 kind_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  idx_t                       idx_q;
  logic                       hit_q;
  logic                       sweep_item;

  idx_t                       sweep;
  logic [COUNT_W-1:0]         cnt;
  logic [COUNT_W-1:0]         cnt_next;

  // RAM ports
  logic                       ram_we;
  idx_t                       ram_waddr;
  sum_t                       ram_wdata;
  idx_t                       ram_raddr;
  sum_t                       ram_rdata;

  logic                       accept;
  logic                       fire;
  logic                       hit_in;
  logic                       out_free;
  sum_t                       sum_add;
  logic signed [SUM_WIDTH:0]  sum_wide;
  sum_t                       touched;
  logic signed [63:0]         touched_ext;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign fire       = (state == S_CALC) && out_free;

  // label range: non-negative and below min(bin_limit, BINS)
  always_comb begin
    hit_in = !region[REGION_W-1]
             && (32'(unsigned'(region)) < 32'(bin_limit))
             && (32'(unsigned'(region)) < 32'(BINS));
  end

  rstc_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hold the read address while waiting in CALC so rdata stays valid
  assign ram_raddr = (state == S_IDLE) ? region[IDX_W-1:0] : idx_q;

  // saturating add of the sign-extended sample
  always_comb begin
    sum_wide = (SUM_WIDTH+1)'(ram_rdata) + (SUM_WIDTH+1)'(sample_q);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_add = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_add = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    touched = '0;
    case (kind_q)
      KIND_ACC:  touched = hit_q ? sum_add : '0;
      KIND_READ: touched = hit_q ? ram_rdata : '0;
      default:   touched = '0;
    endcase
    touched_ext = 64'(touched);
  end

  always_comb begin
    cnt_next = cnt;
    if (kind_q == KIND_ACC && sample_q > threshold && cnt != '1) begin
      cnt_next = cnt + COUNT_W'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = sum_add;
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = '0;
    end else if (fire && kind_q == KIND_ACC && hit_q) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep == idx_t'(BINS-1)) begin
          state_next = sweep_item ? S_CALC : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_CLR) ? S_SWEEP : S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep        <= '0;
      sweep_item   <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
      threshold    <= '0;
      bin_limit    <= RCOUNT_W'(1024);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD) begin
          threshold <= cfg_data;
        end else if (cfg_index == REG_REGION_COUNT) begin
          bin_limit <= cfg_data[RCOUNT_W-1:0];
        end
      end
      if (state == S_SWEEP) begin
        if (sweep == idx_t'(BINS-1)) begin
          sweep <= '0;
        end else begin
          sweep <= sweep + idx_t'(1);
        end
      end
      if (accept) begin
        sweep_item <= (kind == KIND_CLR);
        if (kind == KIND_CLR) begin
          cnt <= '0;
        end
      end
      if (fire) begin
        cnt          <= cnt_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      sample_q <= sample;
      idx_q    <= region[IDX_W-1:0];
      hit_q    <= hit_in;
    end
    if (fire) begin
      region_sum   <= touched_ext[RSUM_W-1:0];
      active_count <= cnt_next;
    end
  end

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !item_ready)
    else $error("item accepted during bin sweep");

  a_clear_zeroes_count: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_CLR) |=> (cnt == '0))
    else $error("clear request did not zero the count");

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SWEEP || state == S_CALC))
    else $error("bin RAM written outside sweep or update");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> (result_valid && state == S_IDLE))
    else $error("completed request did not load a result");

endmodule
`default_nettype wire
